>>> design/shader_wave_generator_defines.svh
// Assertion macros shared by the shader wave generator RTL.
`ifndef SHADER_WAVE_GENERATOR_DEFINES_SVH
`define SHADER_WAVE_GENERATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SWG_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define SWG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/swg_pkg.sv
`default_nettype none

package swg_pkg;

   // Sine table resolution: quarter wave in 2^SINE_TABLE_BITS steps
   localparam int SINE_TABLE_BITS = 10;
   localparam int SINE_N          = 1 << SINE_TABLE_BITS;
   localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;

   // Waveform kinds
   localparam logic [2:0] FUNC_SINE     = 3'd0;
   localparam logic [2:0] FUNC_TRIANGLE = 3'd1;
   localparam logic [2:0] FUNC_SQUARE   = 3'd2;
   localparam logic [2:0] FUNC_SAW      = 3'd3;
   localparam logic [2:0] FUNC_INV_SAW  = 3'd4;
   localparam logic [2:0] FUNC_NOISE    = 3'd5;

   // Wave scale: +1.0 in Q1.15
   localparam logic signed [16:0] WAVE_ONE = 17'sd32768;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [15:0] sine_rom_type [0:SINE_N];

   // Stage 1 request: product bits of time*frequency plus operands
   typedef struct packed {
      logic        [2:0]  func;
      logic        [15:0] pos_hi;
      logic        [15:0] phase_lo;
      logic signed [23:0] base;
      logic signed [23:0] amp;
      logic        [15:0] noise;
   } swg_s1_type;

   // Stage 3 request: wave value ready for scaling
   typedef struct packed {
      logic signed [16:0] wave;
      logic signed [23:0] base;
      logic signed [23:0] amp;
   } swg_s3_type;

   // Stage 4 request: scaled product and offset
   typedef struct packed {
      logic signed [40:0] prod;
      logic signed [23:0] base;
   } swg_s4_type;

   // Build the quarter-wave sine table at elaboration (Q30 Taylor series)
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  q;
      for (int i = 0; i <= SINE_N; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd210;
         sum  = sum - term;
         q    = (sum + 64'd16384) >> 15;
         if (q > 64'd32768) begin
            q = 64'd32768;
         end
         rom[i] = q[15:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

>>> design/swg_phase.sv
`default_nettype none

module swg_phase (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_take,
   input  wire logic [2:0]          func,
   input  wire logic [31:0]         time_now,
   input  wire logic signed [23:0]  frequency,
   input  wire logic signed [23:0]  phase_offset,
   input  wire logic signed [23:0]  base_level,
   input  wire logic signed [23:0]  amplitude,
   input  wire logic [15:0]         noise_sample,
   input  wire logic                out_take,
   output logic                     out_valid,
   output swg_pkg::swg_s1_type      out_data
);
   import swg_pkg::*;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   swg_s1_type         s1_data_ff;
   swg_s1_type         s1_data_in;
   logic signed [56:0] prod;

   // Stage 1 loads when empty or when the next stage takes its request
   assign in_take = !s1_valid_ff || out_take;

   // Form time*frequency; only the low 32 bits matter after the wrap
   assign prod = 57'($signed({1'b0, time_now})) * 57'(frequency);

   always_comb begin
      s1_valid_in         = s1_valid_ff;
      s1_data_in.func     = func;
      s1_data_in.pos_hi   = prod[31:16];
      s1_data_in.phase_lo = phase_offset[15:0];
      s1_data_in.base     = base_level;
      s1_data_in.amp      = amplitude;
      s1_data_in.noise    = noise_sample;
      if (in_take) begin
         s1_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the payload while stalled
   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         s1_data_ff <= s1_data_in;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_data  = s1_data_ff;

endmodule

`default_nettype wire

>>> design/swg_shape.sv
`default_nettype none

`include "shader_wave_generator_defines.svh"

module swg_shape (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_take,
   input  wire swg_pkg::swg_s1_type in_data,
   input  wire logic                out_take,
   output logic                     out_valid,
   output swg_pkg::swg_s3_type      out_data
);
   import swg_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic                         s2_valid_ff;
   logic                         s2_take;
   logic                         s2_sine_ff;
   logic                         s2_neg_ff;
   logic signed [16:0]           s2_wave_ff;
   logic signed [23:0]           s2_base_ff;
   logic signed [23:0]           s2_amp_ff;
   logic [15:0]                  rom_data_ff;
   logic                         s3_valid_ff;
   swg_s3_type                   s3_data_ff;
   swg_s3_type                   s3_data_in;

   logic [15:0]                  t;
   logic [SINE_TABLE_BITS-1:0]   idx;
   logic [SINE_ADDR_W-1:0]       rom_addr;
   logic signed [18:0]           tri_wave;
   logic signed [16:0]           other_wave;
   logic signed [16:0]           sine_wave;

   // Enables ripple back from the output side
   assign s2_take = !s3_valid_ff || out_take;
   assign in_take = !s2_valid_ff || s2_take;

   // Wrap the position: only bits above the fraction point carry into t
   assign t   = in_data.pos_hi + in_data.phase_lo;
   assign idx = t[13 -: SINE_TABLE_BITS];

   // Mirror the index in odd quadrants
   assign rom_addr = t[14] ? (SINE_ADDR_W'(SINE_N) - {1'b0, idx}) : {1'b0, idx};

   // Evaluate the waves that need no table
   always_comb begin
      tri_wave = t[15] ? (19'sd98304 - 19'($signed({2'b00, t, 1'b0})))
                       : (19'($signed({2'b00, t, 1'b0})) - 19'sd32768);
      unique case (in_data.func)
         FUNC_TRIANGLE: other_wave = tri_wave[16:0];
         FUNC_SQUARE:   other_wave = t[15] ? -WAVE_ONE : WAVE_ONE;
         FUNC_SAW:      other_wave = $signed({2'b00, t[15:1]});
         FUNC_INV_SAW:  other_wave = WAVE_ONE - $signed({2'b00, t[15:1]});
         FUNC_NOISE:    other_wave = $signed({2'b00, in_data.noise[15:1]});
         default:       other_wave = 17'sd0;
      endcase
   end

   // Stage 2: table read and other waves
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (in_take) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         rom_data_ff <= SINE_ROM[rom_addr];
         s2_sine_ff  <= (in_data.func == FUNC_SINE);
         s2_neg_ff   <= t[15];
         s2_wave_ff  <= other_wave;
         s2_base_ff  <= in_data.base;
         s2_amp_ff   <= in_data.amp;
      end
   end

   // Stage 3: apply the quadrant sign and pick the wave
   assign sine_wave = s2_neg_ff ? -$signed({1'b0, rom_data_ff}) : $signed({1'b0, rom_data_ff});

   always_comb begin
      s3_data_in.wave = s2_sine_ff ? sine_wave : s2_wave_ff;
      s3_data_in.base = s2_base_ff;
      s3_data_in.amp  = s2_amp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s2_take) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take && s2_valid_ff) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

   `SWG_ASSERT_SAME(a_rom_addr_range, clock, reset, in_valid,
      rom_addr <= SINE_ADDR_W'(SINE_N), "sine table address beyond quarter wave")
   `SWG_ASSERT_SAME(a_wave_range, clock, reset, s3_valid_ff,
      (s3_data_ff.wave <= WAVE_ONE) && (s3_data_ff.wave >= -WAVE_ONE),
      "wave value outside [-1,+1]")

endmodule

`default_nettype wire

>>> design/swg_scale.sv
`default_nettype none

module swg_scale (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_take,
   input  wire swg_pkg::swg_s3_type in_data,
   input  wire logic                out_take,
   output logic                     out_valid,
   output swg_pkg::swg_s4_type      out_data
);
   import swg_pkg::*;

   logic       s4_valid_ff;
   swg_s4_type s4_data_ff;
   swg_s4_type s4_data_in;

   assign in_take = !s4_valid_ff || out_take;

   // Stage 4: amplitude times wave, Q.31
   always_comb begin
      s4_data_in.prod = 41'(in_data.amp) * 41'(in_data.wave);
      s4_data_in.base = in_data.base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (in_take) begin
         s4_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

`default_nettype wire

>>> design/shader_wave_generator.sv
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall func, time_now, frequency, phase_offset,
//                                          base_level, amplitude, noise_sample
// rsp_      out        rsp_valid/rsp_stall wave_value
//
// Five register stages: phase multiply, table read, wave select, amplitude
// multiply, round and offset. One request per cycle unless the output stalls.
// The sine table is a constant ROM with a registered read in stage two.
// Reset clears only the stage valid bits. A stage loads when it is empty or
// the stage after it moves, so bubbles fill while the output is stalled.
`default_nettype none

`include "shader_wave_generator_defines.svh"

module shader_wave_generator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_func,
   input  wire logic [31:0]        req_time_now,
   input  wire logic signed [23:0] req_frequency,
   input  wire logic signed [23:0] req_phase_offset,
   input  wire logic signed [23:0] req_base_level,
   input  wire logic signed [23:0] req_amplitude,
   input  wire logic [15:0]        req_noise_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_wave_value
);
   import swg_pkg::*;

   logic               phase_take;
   logic               s1_valid;
   swg_s1_type         s1_data;
   logic               shape_take;
   logic               s3_valid;
   swg_s3_type         s3_data;
   logic               scale_take;
   logic               s4_valid;
   swg_s4_type         s4_data;
   logic               s5_take;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic signed [40:0] rounded;
   logic signed [26:0] sum;

   swg_phase u_phase (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_take      (phase_take),
      .func         (req_func),
      .time_now     (req_time_now),
      .frequency    (req_frequency),
      .phase_offset (req_phase_offset),
      .base_level   (req_base_level),
      .amplitude    (req_amplitude),
      .noise_sample (req_noise_sample),
      .out_take     (shape_take),
      .out_valid    (s1_valid),
      .out_data     (s1_data)
   );

   swg_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_take   (shape_take),
      .in_data   (s1_data),
      .out_take  (scale_take),
      .out_valid (s3_valid),
      .out_data  (s3_data)
   );

   swg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_take   (scale_take),
      .in_data   (s3_data),
      .out_take  (s5_take),
      .out_valid (s4_valid),
      .out_data  (s4_data)
   );

   assign req_stall = !phase_take;
   assign s5_take   = !rsp_valid_ff || !rsp_stall;

   // Round Q.31 half up to Q.16 and add the base level; the sum stays far
   // inside the 32-bit range, so the clamp reduces to a sign extension
   assign rounded = s4_data.prod + 41'sd16384;
   assign sum     = 27'(s4_data.base) + 27'($signed(rounded[40:15]));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s5_take) begin
         rsp_valid_ff <= s4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_take && s4_valid) begin
         rsp_value_ff <= 32'(sum);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wave_value = rsp_value_ff;

   `SWG_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall,
      rsp_valid_ff && rsp_stall && s1_valid && s3_valid && s4_valid,
      "request stalled while the pipeline has room")
   `SWG_ASSERT_NEXT(a_result_follows, clock, reset, s4_valid && s5_take,
      rsp_valid_ff, "stage four request lost at the output")

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
   import swg_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_REQUESTS = 700;
   localparam int QUIET_TAIL = 60;

   typedef struct packed {
      logic        [2:0]  func;
      logic        [31:0] time_now;
      logic signed [23:0] frequency;
      logic signed [23:0] phase_offset;
      logic signed [23:0] base_level;
      logic signed [23:0] amplitude;
      logic        [15:0] noise_sample;
   } wave_request_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_func = '0;
   logic [31:0] req_time_now = '0;
   logic signed [23:0] req_frequency = '0;
   logic signed [23:0] req_phase_offset = '0;
   logic signed [23:0] req_base_level = '0;
   logic signed [23:0] req_amplitude = '0;
   logic [15:0] req_noise_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_wave_value;

   wave_request_t request_q[$];
   logic signed [31:0] wave_value_q[$];
   int sine_q15 [0:SINE_N];
   int error_count = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   logic req_blocked = 1'b0;
   logic idling_on = 1'b0;

   shader_wave_generator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_time_now    (req_time_now),
      .req_frequency   (req_frequency),
      .req_phase_offset(req_phase_offset),
      .req_base_level  (req_base_level),
      .req_amplitude   (req_amplitude),
      .req_noise_sample(req_noise_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wave_value  (rsp_wave_value)
   );

   always #2 clock = ~clock;

   // Build the quarter-wave sine table: Q30 Taylor series, rounded to Q15
   function automatic void fill_sine_table();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] q;
      for (int i = 0; i <= SINE_N; i++) begin
         x = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
         x2 = (x * x) >> 30;
         term = x;
         acc = x;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         q = (acc + 64'd16384) >> 15;
         if (q > 64'd32768) begin
            q = 64'd32768;
         end
         sine_q15[i] = int'(q);
      end
   endfunction

   // Compute the saturated wave value for one request
   function automatic logic signed [31:0] predict_wave_value(wave_request_t r);
      longint pos;
      logic [15:0] t;
      logic [1:0] quad;
      int tv;
      int idx;
      int w;
      int one;
      longint prod;
      longint scaled;
      longint total;
      one = int'(WAVE_ONE);
      pos = longint'({32'd0, r.time_now}) * longint'($signed(r.frequency))
            + longint'($signed(r.phase_offset)) * 64'sd65536;
      t = pos[31:16];
      tv = int'({16'd0, t});
      case (r.func)
         FUNC_SINE: begin
            quad = t[15:14];
            idx = int'({18'd0, t[13:0]}) >> (14 - SINE_TABLE_BITS);
            w = quad[0] ? sine_q15[SINE_N - idx] : sine_q15[idx];
            if (quad[1]) begin
               w = -w;
            end
         end
         FUNC_TRIANGLE: w = (tv < 32768) ? 2 * tv - 32768 : 98304 - 2 * tv;
         FUNC_SQUARE:   w = (tv < 32768) ? one : -one;
         FUNC_SAW:      w = tv >> 1;
         FUNC_INV_SAW:  w = one - (tv >> 1);
         FUNC_NOISE:    w = int'({16'd0, r.noise_sample}) >> 1;
         default:       w = 0;
      endcase
      // round half up from Q.31 to Q.16, then add the base level
      prod = longint'($signed(r.amplitude)) * longint'(w);
      scaled = (prod + 64'sd16384) >>> 15;
      total = longint'($signed(r.base_level)) + scaled;
      if (total > 64'sd2147483647) begin
         total = 64'sd2147483647;
      end
      if (total < -64'sd2147483648) begin
         total = -64'sd2147483648;
      end
      return total[31:0];
   endfunction

   function automatic void add_request(logic [2:0] func, logic [31:0] time_now,
                                       logic [23:0] frequency, logic [23:0] phase_offset,
                                       logic [23:0] base_level, logic [23:0] amplitude,
                                       logic [15:0] noise_sample);
      wave_request_t r;
      r.func = func;
      r.time_now = time_now;
      r.frequency = frequency;
      r.phase_offset = phase_offset;
      r.base_level = base_level;
      r.amplitude = amplitude;
      r.noise_sample = noise_sample;
      request_q.push_back(r);
   endfunction

   // Pick a Q8.16 value, now and then at an end of the range
   function automatic logic [23:0] pick_q8_16();
      logic [23:0] v;
      case ($urandom_range(0, 9))
         0:       v = 24'h7FFFFF;
         1:       v = 24'h800000;
         2:       v = 24'($signed($urandom_range(0, 262143)) - 131072);
         default: v = 24'($urandom);
      endcase
      return v;
   endfunction

   task automatic load_requests();
      logic [2:0] func;
      logic [31:0] time_now;
      logic [23:0] frequency;
      // every kind at one position, the unknown kinds among them
      for (int k = 0; k < 8; k++) begin
         add_request(3'(k), 32'd0, 24'd0, 24'h002000, 24'h010000, 24'h010000, 16'hABCD);
      end
      // sine quadrant edges and the top of the position
      add_request(FUNC_SINE, 32'd0, 24'd0, 24'h004000, 24'd0, 24'h7FFFFF, 16'd0);
      add_request(FUNC_SINE, 32'd0, 24'd0, 24'h008000, 24'd0, 24'h7FFFFF, 16'd0);
      add_request(FUNC_SINE, 32'd0, 24'd0, 24'h00C000, 24'd0, 24'h800000, 16'd0);
      add_request(FUNC_SINE, 32'd0, 24'd0, 24'h00FFFF, 24'd0, 24'h800000, 16'd0);
      // triangle and square on either side of the half cycle
      add_request(FUNC_TRIANGLE, 32'd0, 24'd0, 24'h007FFF, 24'd0, 24'h010000, 16'd0);
      add_request(FUNC_TRIANGLE, 32'd0, 24'd0, 24'h008000, 24'd0, 24'h010000, 16'd0);
      add_request(FUNC_SQUARE, 32'd0, 24'd0, 24'h007FFF, 24'd0, 24'h010000, 16'd0);
      add_request(FUNC_SQUARE, 32'd0, 24'd0, 24'h008000, 24'd0, 24'h010000, 16'd0);
      // negative positions wrap to a true fraction
      add_request(FUNC_SAW, 32'h00018000, 24'hFF0000, 24'd0, 24'd0, 24'h010000, 16'd0);
      add_request(FUNC_INV_SAW, 32'd0, 24'd0, 24'hFFC000, 24'd0, 24'h010000, 16'd0);
      // field extremes on both ends of the output
      add_request(FUNC_SQUARE, 32'hFFFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                  24'h7FFFFF, 16'hFFFF);
      add_request(FUNC_INV_SAW, 32'hFFFFFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                  24'h800000, 16'd0);
      add_request(FUNC_NOISE, 32'd0, 24'd0, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
      add_request(FUNC_NOISE, 32'd0, 24'd0, 24'd0, 24'h800000, 24'h800000, 16'hFFFF);
      add_request(3'd7, 32'hFFFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                  16'hFFFF);
      // random requests, some with no frequency or slow sweeps
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         func = 3'($urandom_range(0, 7));
         time_now = $urandom;
         frequency = pick_q8_16();
         case ($urandom_range(0, 3))
            0: frequency = 24'd0;
            1: time_now = 32'($urandom_range(0, 1048575));
            default: ;
         endcase
         add_request(func, time_now, frequency, pick_q8_16(), pick_q8_16(),
                     pick_q8_16(), 16'($urandom));
      end
   endtask

   // Drive requests at the falling edge, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && req_blocked) begin
         // hold the stalled request
      end else if (req_gap != 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (request_q.size() != 0 && idling_on && $urandom_range(0, 3) == 0) begin
         req_gap <= $urandom_range(0, 3);
         req_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
         req_valid <= 1'b1;
         req_func <= request_q[0].func;
         req_time_now <= request_q[0].time_now;
         req_frequency <= request_q[0].frequency;
         req_phase_offset <= request_q[0].phase_offset;
         req_base_level <= request_q[0].base_level;
         req_amplitude <= request_q[0].amplitude;
         req_noise_sample <= request_q[0].noise_sample;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Stall the result channel in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
         rsp_gap <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Record accepted requests and check results at the rising edge
   always @(posedge clock) begin : monitor
      logic signed [31:0] want;
      cycle_count <= cycle_count + 1;
      // alternate idling and calm stretches, and go calm at the tail
      idling_on <= (cycle_count % 600) < 400 && request_q.size() > QUIET_TAIL;
      req_blocked <= req_valid && req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            wave_value_q.push_back(predict_wave_value(request_q[0]));
            void'(request_q.pop_front());
         end
         if (rsp_valid && !rsp_stall) begin
            if (wave_value_q.size() == 0) begin
               $display("%0t: unexpected wave_value, expected none, actual %0d",
                        $time, rsp_wave_value);
               error_count <= error_count + 1;
            end else begin
               want = wave_value_q.pop_front();
               if (rsp_wave_value !== want) begin
                  $display("%0t: wave_value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_wave_value);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("shader_wave_generator test failed");
         $finish;
      end
   end

   initial begin
      fill_sine_table();
      load_requests();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // wait for every request and result, then let the pipeline drain
      @(posedge clock);
      while (request_q.size() != 0 || wave_value_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("shader_wave_generator test passed");
      end else begin
         $display("shader_wave_generator test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
